// ===== design/ple_pkg.sv =====
// Shared types, codes and sizes for the positional list engine.
package ple_pkg;

   // Default list capacity and fixed field widths
   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned FUNC_W        = 3;
   localparam int unsigned POS_W         = 8;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned LEN_W         = 5;

   // Operation codes carried in the func field
   localparam logic [FUNC_W-1:0] FUNC_INS_HEAD = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INS_TAIL = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INS_POS  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   // Request and response beats
   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] read_value;
      logic signed [DATA_W-1:0] head_value;
      logic signed [DATA_W-1:0] tail_value;
      logic [LEN_W-1:0]         length;
   } rsp_type;

   // Work class of a decoded request; failed requests become OP_NONE
   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_DELETE,
      OP_READ
   } op_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_COMMIT,
      ST_RD_ITEM,
      ST_RD_HEAD,
      ST_RD_TAIL,
      ST_RESP
   } state_type;

   // Commands from sequencer to datapath
   typedef struct packed {
      logic accept;
      logic shift_rd;
      logic shift_wr;
      logic place;
      logic commit_del;
      logic rd_pos;
      logic rd_head;
      logic rd_tail;
      logic cap_item;
      logic cap_head;
      logic load_rsp;
   } cmd_type;

   // Status from datapath to sequencer
   typedef struct packed {
      op_type op;
      logic   shift_done;
      logic   rsp_free;
   } sts_type;

endpackage

// ===== design/ple_ctrl.sv =====
// Sequencer for the positional list engine: steps each request through its phases.
module ple_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ple_pkg::sts_type sts,
   output ple_pkg::cmd_type cmd
);
   import ple_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold or advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (sts.op)
               OP_INSERT: state_in = ST_SHIFT_RD;
               OP_DELETE: state_in = ST_SHIFT_RD;
               OP_READ:   state_in = ST_RD_ITEM;
               default:   state_in = ST_RD_HEAD;
            endcase
         end
         ST_SHIFT_RD: begin
            if (!sts.shift_done) begin
               state_in = ST_SHIFT_WR;
            end else if (sts.op == OP_INSERT) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_PLACE:    state_in = ST_RD_HEAD;
         ST_COMMIT:   state_in = ST_RD_HEAD;
         ST_RD_ITEM:  state_in = ST_RD_HEAD;
         ST_RD_HEAD:  state_in = ST_RD_TAIL;
         ST_RD_TAIL:  state_in = ST_RESP;
         ST_RESP: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SHIFT_RD: cmd.shift_rd = !sts.shift_done;
         ST_SHIFT_WR: cmd.shift_wr = 1'b1;
         ST_PLACE:    cmd.place = 1'b1;
         ST_COMMIT:   cmd.commit_del = 1'b1;
         ST_RD_ITEM:  cmd.rd_pos = 1'b1;
         ST_RD_HEAD: begin
            cmd.rd_head  = 1'b1;
            cmd.cap_item = (sts.op == OP_READ);
         end
         ST_RD_TAIL: begin
            cmd.rd_tail  = 1'b1;
            cmd.cap_head = 1'b1;
         end
         ST_RESP:     cmd.load_rsp = sts.rsp_free;
         default: ;
      endcase
   end

endmodule

// ===== design/ple_dpath.sv =====
// Datapath for the positional list engine: entry memory, count, pointers and response register.
module ple_dpath #(
   parameter int unsigned DEPTH = ple_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  ple_pkg::req_type req_data,
   input  ple_pkg::cmd_type cmd,
   output ple_pkg::sts_type sts,
   output ple_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_ready
);
   import ple_pkg::*;

   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned AW   = $clog2(DEPTH);
   localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

   // Entry memory, one write and one registered read per cycle
   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;

   // Control registers
   logic [CW-1:0] count_ff;
   op_type        op_ff;
   logic          rsp_valid_ff;

   // Payload registers
   logic [STATUS_W-1:0]      status_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] rdv_ff;
   logic signed [DATA_W-1:0] head_ff;
   logic [CW-1:0]            idx_ff;
   logic [CW-1:0]            ptr_ff;
   rsp_type                  rsp_ff;

   // Decode of the incoming beat
   op_type              op_in;
   logic [STATUS_W-1:0] status_in;
   logic [CW-1:0]       idx_in;
   logic [CW-1:0]       ptr_in;
   logic [CMPW-1:0]     pos_ext;
   logic [CMPW-1:0]     cnt_ext;
   logic [CW-1:0]       pos_cw;
   logic                pos_ok;
   logic                full;

   // Memory port selection
   logic          rd_en;
   logic [CW-1:0] rd_addr;
   logic          wr_en;
   logic signed [DATA_W-1:0] wr_data;
   logic          shift_down;
   logic [CW-1:0] ptr_step;

   rsp_type rsp_in;

   assign pos_ext = CMPW'(req_data.position);
   assign cnt_ext = CMPW'(count_ff);
   assign pos_cw  = pos_ext[CW-1:0];
   assign pos_ok  = (pos_ext < cnt_ext);
   assign full    = (count_ff == CW'(DEPTH));

   // Classify the request and choose the starting pointer
   always_comb begin
      op_in     = OP_NONE;
      status_in = STATUS_OK;
      idx_in    = count_ff;
      ptr_in    = count_ff;
      unique case (req_data.func)
         FUNC_INS_HEAD, FUNC_INS_TAIL, FUNC_INS_POS: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               op_in = OP_INSERT;
               if (req_data.func == FUNC_INS_HEAD) begin
                  idx_in = '0;
               end else if (req_data.func == FUNC_INS_POS && pos_ok) begin
                  idx_in = pos_cw;
               end
            end
         end
         FUNC_DELETE: begin
            ptr_in = pos_cw;
            if (pos_ok) op_in = OP_DELETE;
            else        status_in = STATUS_BADPOS;
         end
         FUNC_READ: begin
            ptr_in = pos_cw;
            if (pos_ok) op_in = OP_READ;
            else        status_in = STATUS_BADPOS;
         end
         default: ;
      endcase
   end

   // Insert opens a gap by moving entries towards the tail; delete closes one towards the head
   assign shift_down = (op_ff == OP_INSERT);
   assign ptr_step   = shift_down ? (ptr_ff - CW'(1)) : (ptr_ff + CW'(1));

   assign sts.op         = op_ff;
   assign sts.shift_done = shift_down ? (ptr_ff == idx_ff)
                                      : ((ptr_ff + CW'(1)) == count_ff);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   // Read address
   always_comb begin
      rd_en   = cmd.shift_rd || cmd.rd_pos || cmd.rd_head || cmd.rd_tail;
      rd_addr = ptr_ff;
      priority if (cmd.shift_rd) begin
         rd_addr = ptr_step;
      end else if (cmd.rd_head) begin
         rd_addr = '0;
      end else if (cmd.rd_tail) begin
         rd_addr = count_ff - CW'(1);
      end else begin
         rd_addr = ptr_ff;
      end
   end

   assign wr_en   = cmd.shift_wr || cmd.place;
   assign wr_data = cmd.shift_wr ? rdata_ff : value_ff;

   // Entry memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[ptr_ff[AW-1:0]] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr[AW-1:0]];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) op_ff <= op_in;
         if (cmd.place) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.commit_del) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Latch the request, step the pointer, capture read data
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_ff <= status_in;
         value_ff  <= req_data.value;
         idx_ff    <= idx_in;
         ptr_ff    <= ptr_in;
         rdv_ff    <= '0;
      end else begin
         if (cmd.shift_wr) ptr_ff <= ptr_step;
         if (cmd.cap_item) rdv_ff <= rdata_ff;
      end
      if (cmd.cap_head) head_ff <= rdata_ff;
      if (cmd.load_rsp) rsp_ff <= rsp_in;
   end

   // Assemble the response; the tail entry is still on the read port
   always_comb begin
      rsp_in.status     = status_ff;
      rsp_in.read_value = rdv_ff;
      rsp_in.head_value = (count_ff == '0) ? '0 : head_ff;
      rsp_in.tail_value = (count_ff == '0) ? '0 : rdata_ff;
      rsp_in.length     = LEN_W'(count_ff);
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list count above capacity");

   a_place_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   a_err_no_work: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift_rd || cmd.place || cmd.commit_del) |-> status_ff == STATUS_OK)
      else $error("list changed on a failed request");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

endmodule

// ===== design/positional_list_engine_top.sv =====
// Top level of the positional list engine: sequencer plus datapath.
// Ordered list of up to DEPTH signed 32-bit values kept packed from the head in a
// single-port-write entry memory. One request is taken at a time and each yields one
// response beat. An insert moves length - index entries and a delete moves
// length - 1 - position entries; a read, a failed or an unused request moves none.
// Every moved entry costs one read and one write of the entry memory, and head
// and tail are read back from it before the response is formed. A new request is taken
// once the previous response is in the output register, even if it has not been drained.
module positional_list_engine_top #(
   parameter int unsigned DEPTH = ple_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ple_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ple_pkg::rsp_type rsp_data
);
   import ple_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ple_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

// ===== verif/tb_positional_list_engine_top.sv =====
// Self-checking testbench for the positional list engine: directed table then random beats.
`timescale 1ns / 100ps

module tb_positional_list_engine_top;
   import ple_pkg::*;

   localparam int unsigned LIST_DEPTH    = DEPTH_DEFAULT;
   localparam int          RANDOM_ITEMS  = 1500;
   localparam int          QUIET_TAIL    = 200;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          DRAIN_LIMIT   = 5000;
   localparam int          SETTLE_CYCLES = 60;

   // Codes 5 to 7 carry no operation
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

   typedef enum int {MIX_MODE, FILL_MODE, DRAIN_MODE} phase_kind_type;

   typedef struct {
      req_type beat;
      bit      has_golden;
      rsp_type golden;
   } table_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the list and the results still owed by the block
   logic signed [DATA_W-1:0] list_store [LIST_DEPTH];
   int      list_len = 0;
   rsp_type owed_rsp [$];
   table_row_type directed_rows [$];

   bit idle_on          = 1'b1;
   int sink_hold_cycles = 0;
   int fail_count       = 0;
   int beats_sent       = 0;
   int beats_checked    = 0;
   int peak_len         = 0;
   int func_seen   [8];
   int status_seen [4];

   positional_list_engine_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one operation to the shadow list and form the result it gives
   function automatic rsp_type apply_list_op(input req_type r);
      rsp_type res;
      int      idx;
      res = '0;
      res.status = STATUS_OK;
      case (r.func)
         FUNC_INS_HEAD, FUNC_INS_TAIL, FUNC_INS_POS: begin
            if (list_len >= LIST_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               if (r.func == FUNC_INS_HEAD) idx = 0;
               else if (r.func == FUNC_INS_TAIL) idx = list_len;
               else idx = (r.position < list_len) ? int'(r.position) : list_len;
               for (int k = list_len; k > idx; k--) list_store[k] = list_store[k-1];
               list_store[idx] = r.value;
               list_len++;
            end
         end
         FUNC_DELETE: begin
            if (r.position >= list_len) begin
               res.status = STATUS_BADPOS;
            end else begin
               for (int k = int'(r.position); k + 1 < list_len; k++)
                  list_store[k] = list_store[k+1];
               list_len--;
            end
         end
         FUNC_READ: begin
            if (r.position >= list_len) res.status = STATUS_BADPOS;
            else res.read_value = list_store[r.position];
         end
         default: ;
      endcase
      if (list_len != 0) begin
         res.head_value = list_store[0];
         res.tail_value = list_store[list_len-1];
      end
      res.length = LEN_W'(list_len);
      return res;
   endfunction

   function automatic req_type mk_req(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v,
                                      input logic [POS_W-1:0] p);
      req_type r;
      r.func     = f;
      r.value    = v;
      r.position = p;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic [STATUS_W-1:0] st, input logic [DATA_W-1:0] rd,
                                      input logic [DATA_W-1:0] hd, input logic [DATA_W-1:0] tl,
                                      input logic [LEN_W-1:0] len);
      rsp_type r;
      r.status     = st;
      r.read_value = rd;
      r.head_value = hd;
      r.tail_value = tl;
      r.length     = len;
      return r;
   endfunction

   function automatic void add_row(input req_type beat, input bit has_golden,
                                   input rsp_type golden);
      table_row_type row;
      row.beat       = beat;
      row.has_golden = has_golden;
      row.golden     = golden;
      directed_rows.push_back(row);
   endfunction

   // Draw one request, biased towards positions that land inside the list
   function automatic req_type pick_list_op(input phase_kind_type kind);
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r.value = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: r.value = 32'h0000_0000;
            1: r.value = 32'h7FFF_FFFF;
            2: r.value = 32'h8000_0000;
            default: r.value = 32'hFFFF_FFFF;
         endcase
      end
      if ($urandom_range(0, 9) == 0) r.position = POS_W'($urandom_range(0, 255));
      else r.position = POS_W'($urandom_range(0, list_len));
      case (kind)
         FILL_MODE: begin
            if (roll < 30) r.func = FUNC_INS_HEAD;
            else if (roll < 60) r.func = FUNC_INS_TAIL;
            else if (roll < 90) r.func = FUNC_INS_POS;
            else r.func = FUNC_READ;
         end
         DRAIN_MODE: begin
            if (roll < 85) r.func = FUNC_DELETE;
            else r.func = FUNC_READ;
         end
         default: begin
            if (roll < 15) r.func = FUNC_INS_HEAD;
            else if (roll < 30) r.func = FUNC_INS_TAIL;
            else if (roll < 50) r.func = FUNC_INS_POS;
            else if (roll < 70) r.func = FUNC_DELETE;
            else if (roll < 93) r.func = FUNC_READ;
            else r.func = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
         end
      endcase
      return r;
   endfunction

   // Offer one beat, hold it until taken, then record what it should return
   task automatic send_beat(input req_type beat, input bit has_golden, input rsp_type golden);
      rsp_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      predicted = apply_list_op(beat);
      owed_rsp.push_back(has_golden ? golden : predicted);
      func_seen[beat.func]++;
      status_seen[predicted.status]++;
      if (list_len > peak_len) peak_len = list_len;
      beats_sent++;
   endtask

   // Lower valid and wait until the block has returned everything owed
   task automatic pause_sender();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_rsp.size() != 0);
   endtask

   // Drive the result-side ready: long holds on request, random stalls otherwise
   initial begin
      @(posedge clock);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each returned beat with the oldest owed result
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (owed_rsp.size() == 0) begin
            $error("result beat with nothing owed: %p", rsp_data);
            fail_count++;
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value, rsp_data.read_value);
               fail_count++;
            end
            if (rsp_data.head_value !== want.head_value) begin
               $error("head_value: expected %0d, got %0d", want.head_value, rsp_data.head_value);
               fail_count++;
            end
            if (rsp_data.tail_value !== want.tail_value) begin
               $error("tail_value: expected %0d, got %0d", want.tail_value, rsp_data.tail_value);
               fail_count++;
            end
            if (rsp_data.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_data.length);
               fail_count++;
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      phase_kind_type kind;
      int             burst;
      int             sent;
      int             waited;
      bit             hold_done;
      bit             pause_done;

      // Empty-list accesses, extremes, clamping, sole-element delete, then fill past full
      add_row(mk_req(FUNC_READ, 32'd0, 8'd0), 1'b1, mk_rsp(STATUS_BADPOS, '0, '0, '0, '0));
      add_row(mk_req(FUNC_DELETE, 32'd0, 8'd0), 1'b1, mk_rsp(STATUS_BADPOS, '0, '0, '0, '0));
      add_row(mk_req(FUNC_UNUSED_HI, 32'hFFFF_FFFF, 8'hFF), 1'b1,
              mk_rsp(STATUS_OK, '0, '0, '0, '0));
      add_row(mk_req(FUNC_INS_HEAD, 32'h7FFF_FFFF, 8'd0), 1'b1,
              mk_rsp(STATUS_OK, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1));
      add_row(mk_req(FUNC_DELETE, 32'd0, 8'd0), 1'b1, mk_rsp(STATUS_OK, '0, '0, '0, '0));
      add_row(mk_req(FUNC_INS_TAIL, 32'h8000_0000, 8'd0), 1'b1,
              mk_rsp(STATUS_OK, '0, 32'h8000_0000, 32'h8000_0000, 5'd1));
      add_row(mk_req(FUNC_INS_POS, 32'hFFFF_FFFF, 8'hFF), 1'b1,
              mk_rsp(STATUS_OK, '0, 32'h8000_0000, 32'hFFFF_FFFF, 5'd2));
      add_row(mk_req(FUNC_INS_POS, 32'd0, 8'd0), 1'b0, '0);
      add_row(mk_req(FUNC_INS_POS, 32'h5555_5555, 8'd1), 1'b0, '0);
      add_row(mk_req(FUNC_READ, 32'd0, 8'd3), 1'b0, '0);
      add_row(mk_req(FUNC_DELETE, 32'd0, 8'd4), 1'b0, '0);
      for (int i = 0; i < 12; i++)
         add_row(mk_req(FUNC_W'(i % 3), $urandom, POS_W'($urandom_range(0, 255))), 1'b0, '0);
      add_row(mk_req(FUNC_INS_HEAD, 32'h1234_5678, 8'd0), 1'b0, '0);
      add_row(mk_req(FUNC_DELETE, 32'd0, 8'd15), 1'b0, '0);
      add_row(mk_req(FUNC_READ, 32'd0, 8'd0), 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].has_golden, directed_rows[i].golden);

      // Random bursts of fill, drain and mixed traffic
      sent       = 0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: kind = FILL_MODE;
            1: kind = DRAIN_MODE;
            default: kind = MIX_MODE;
         endcase
         burst   = $urandom_range(8, 40);
         idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         if (!hold_done && sent >= 300) begin
            sink_hold_cycles = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (!pause_done && sent >= 700) begin
            pause_sender();
            pause_done = 1'b1;
         end
         repeat (burst) begin
            send_beat(pick_list_op(kind), 1'b0, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;

      // Wait for the owed results, then give stray beats a chance to show
      waited = 0;
      while (owed_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (owed_rsp.size() != 0) begin
         $error("%0d results never returned", owed_rsp.size());
         fail_count++;
      end

      $display("Sent %0d requests (%0d from the table), checked %0d result beats, peak length %0d.",
               beats_sent, directed_rows.size(), beats_checked, peak_len);
      $display("Outcomes: %0d ok, %0d bad position, %0d full; %0d unused codes.",
               status_seen[STATUS_OK], status_seen[STATUS_BADPOS], status_seen[STATUS_FULL],
               func_seen[FUNC_UNUSED_LO] + func_seen[FUNC_UNUSED_LO + 3'd1]
               + func_seen[FUNC_UNUSED_HI]);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/ple_pkg.sv
design/ple_ctrl.sv
design/ple_dpath.sv
design/positional_list_engine_top.sv
verif/tb_positional_list_engine_top.sv
